// ----- hw/rtl/gpc_pkg.sv -----
// shared constants and codes for the goldbach pair counter
`default_nettype none

package gpc_pkg;

  // default depth of the prime map, one bit per number
  localparam int unsigned SIEVE_SIZE_DEF = 65536;

  // field widths
  localparam int unsigned NUM_W    = 16;  // number and limit
  localparam int unsigned CNT_W    = 17;  // walk counter, reaches limit + 1
  localparam int unsigned ROOT_W   = 9;   // sieve prime, stays at or below 256
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PRIME_W  = 13;
  localparam int unsigned PAIR_W   = 15;

  // configuration port
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic [0:0]  REG_SIEVE_LIMIT = 1'b0;
  localparam logic [NUM_W-1:0] SIEVE_LIMIT_RST = 16'hFFFF;

  // operation codes
  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/gpc_in_if.sv -----
// input channel: operation and number words
`default_nettype none

interface gpc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [gpc_pkg::NUM_W-1:0]   number;

  modport source (output valid, output operation, output number, input ready);
  modport sink   (input valid, input operation, input number, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gpc_out_if.sv -----
// result channel: status, primes found and pair count words
`default_nettype none

interface gpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [gpc_pkg::STATUS_W-1:0]  status;
  logic [gpc_pkg::PRIME_W-1:0]   primes_found;
  logic [gpc_pkg::PAIR_W-1:0]    pair_count;

  modport source (output valid, output status, output primes_found, output pair_count,
                  input ready);
  modport sink   (input valid, input status, input primes_found, input pair_count,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/goldbach_pair_counter_unit.sv -----
// goldbach pair counter: prime map memory, sieve sequencer and pair walker
//
//   channel   dir  handshake             payload
//   in_ch     in   valid / ready         operation, number
//   out_ch    out  valid / ready         status, primes_found, pair_count
//   apb       in   psel/penable/pready   paddr, pwdata, prdata (sieve_limit at 0)
//
// one item at a time; the map has one write and two read ports, one access each a cycle
// out_ch.valid rises as the result enters the output register, and in_ch.ready returns with idle
// build with limit L: fill the map up to L, then a read and a check per candidate p with p * p <= L,
//   a write per multiple crossed off for each prime, the count reads over 2 to L and a drain
// query on n: pair reads for k from 2 to n / 2, then a drain; a failing query goes straight to done
// synchronous active-low reset clears control and the built flag; the map needs no clearing
// a finished word waits in the output register; a second result waits until it is taken
`default_nettype none

module goldbach_pair_counter_unit #(
  parameter int unsigned SIEVE_SIZE = gpc_pkg::SIEVE_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  gpc_in_if.sink                             in_ch,
  gpc_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gpc_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [gpc_pkg::PDATA_W-1:0]   pwdata,
  output logic      [gpc_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int unsigned AW = $clog2(SIEVE_SIZE);
  localparam int unsigned NW = gpc_pkg::NUM_W;
  localparam int unsigned CW = gpc_pkg::CNT_W;
  localparam int unsigned RW = gpc_pkg::ROOT_W;
  localparam int unsigned PW = gpc_pkg::PAIR_W;
  localparam int unsigned TOP_IDX = (SIEVE_SIZE - 1 > 65535) ? 65535 : SIEVE_SIZE - 1;
  localparam logic [CW-1:0] MAX_IDX = CW'(TOP_IDX);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_PRD   = 4'd2;
  localparam logic [3:0] S_PCHK  = 4'd3;
  localparam logic [3:0] S_CROSS = 4'd4;
  localparam logic [3:0] S_COUNT = 4'd5;
  localparam logic [3:0] S_QUERY = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // configuration
  logic [NW-1:0] sieve_limit_r;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == gpc_pkg::REG_SIEVE_LIMIT) ?
                  {{(gpc_pkg::PDATA_W-NW){1'b0}}, sieve_limit_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sieve_limit_r <= gpc_pkg::SIEVE_LIMIT_RST;
    end else if (cfg_wr && paddr[2] == gpc_pkg::REG_SIEVE_LIMIT) begin
      sieve_limit_r <= pwdata[NW-1:0];
    end
  end

  // control state
  logic [3:0]                    state_r, state_nxt;
  logic [CW-1:0]                 k_r, k_nxt;
  logic [RW-1:0]                 p_r, p_nxt;
  logic [CW-1:0]                 psq_r, psq_nxt;
  logic [NW-1:0]                 built_lim_r, built_lim_nxt;
  logic                          built_r, built_nxt;
  logic [NW-1:0]                 n_r, n_nxt;
  logic                          mode_r, mode_nxt;
  logic [gpc_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [PW-1:0]                 acc_r, acc_nxt;
  logic                          pend_r, pend_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [gpc_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [gpc_pkg::PRIME_W-1:0]   out_prime_r, out_prime_nxt;
  logic [PW-1:0]                 out_pair_r, out_pair_nxt;

  // map memory ports
  logic          map_mem_r [SIEVE_SIZE];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] raddr_a, raddr_b;
  logic          rd_a_r, rd_b_r;

  logic          in_fire;
  logic [CW-1:0] lim_ext;
  logic [NW-1:0] eff_lim;
  logic [CW-1:0] k_step;
  logic [CW-1:0] psq_step;
  logic [CW-1:0] half_n;
  logic [NW-1:0] partner;
  logic          hit;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign eff_lim  = ({1'b0, sieve_limit_r} > MAX_IDX) ? MAX_IDX[NW-1:0] : sieve_limit_r;
  assign lim_ext  = {1'b0, built_lim_r};
  assign k_step   = k_r + CW'(p_r);
  // (p + 1)^2 = p^2 + 2p + 1
  assign psq_step = psq_r + CW'({p_r, 1'b1});
  assign half_n   = CW'(n_r >> 1);
  assign partner  = n_r - k_r[NW-1:0];
  // build counts single bits, query needs both ends of the pair
  assign hit      = pend_r & rd_a_r & ((mode_r == gpc_pkg::OP_BUILD) | rd_b_r);

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    p_nxt          = p_r;
    psq_nxt        = psq_r;
    built_lim_nxt  = built_lim_r;
    built_nxt      = built_r;
    n_nxt          = n_r;
    mode_nxt       = mode_r;
    status_nxt     = status_r;
    acc_nxt        = hit ? acc_r + PW'(1) : acc_r;
    pend_nxt       = 1'b0;
    out_valid_nxt  = out_valid_r & ~out_ch.ready;
    out_status_nxt = out_status_r;
    out_prime_nxt  = out_prime_r;
    out_pair_nxt   = out_pair_r;
    mem_we         = 1'b0;
    mem_waddr      = AW'(k_r);
    mem_wdata      = 1'b0;
    raddr_a        = AW'(k_r);
    raddr_b        = AW'(partner);

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          acc_nxt    = '0;
          mode_nxt   = in_ch.operation;
          status_nxt = gpc_pkg::ST_OK;
          if (in_ch.operation == gpc_pkg::OP_BUILD) begin
            built_lim_nxt = eff_lim;
            built_nxt     = 1'b1;
            k_nxt         = '0;
            state_nxt     = S_INIT;
          end else begin
            n_nxt = in_ch.number;
            k_nxt = CW'(2);
            if (!built_r) begin
              status_nxt = gpc_pkg::ST_NOT_BUILT;
              state_nxt  = S_DONE;
            end else if (in_ch.number > built_lim_r) begin
              status_nxt = gpc_pkg::ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_QUERY;
            end
          end
        end
      end
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = (k_r >= CW'(2));
        if (k_r == lim_ext) begin
          p_nxt     = RW'(2);
          psq_nxt   = CW'(4);
          state_nxt = S_PRD;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      S_PRD: begin
        // crossings of earlier primes are all written before this read
        raddr_a = AW'(p_r);
        if (psq_r > lim_ext) begin
          k_nxt     = CW'(2);
          state_nxt = S_COUNT;
        end else begin
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        if (rd_a_r) begin
          k_nxt     = psq_r;
          state_nxt = S_CROSS;
        end else begin
          p_nxt     = p_r + RW'(1);
          psq_nxt   = psq_step;
          state_nxt = S_PRD;
        end
      end
      S_CROSS: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b0;
        if (k_step > lim_ext) begin
          p_nxt     = p_r + RW'(1);
          psq_nxt   = psq_step;
          state_nxt = S_PRD;
        end else begin
          k_nxt = k_step;
        end
      end
      S_COUNT: begin
        if (k_r > lim_ext) begin
          state_nxt = S_DRAIN;
        end else begin
          pend_nxt = 1'b1;
          k_nxt    = k_r + CW'(1);
        end
      end
      S_QUERY: begin
        if (k_r > half_n) begin
          state_nxt = S_DRAIN;
        end else begin
          pend_nxt = 1'b1;
          k_nxt    = k_r + CW'(1);
        end
      end
      S_DRAIN: begin
        // the accumulator already holds the last read by this state
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_prime_nxt  = (mode_r == gpc_pkg::OP_BUILD) ? acc_r[gpc_pkg::PRIME_W-1:0] : '0;
          out_pair_nxt   = (mode_r == gpc_pkg::OP_QUERY) ? acc_r : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      built_r     <= 1'b0;
      built_lim_r <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      built_r     <= built_nxt;
      built_lim_r <= built_lim_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    p_r          <= p_nxt;
    psq_r        <= psq_nxt;
    n_r          <= n_nxt;
    mode_r       <= mode_nxt;
    status_r     <= status_nxt;
    acc_r        <= acc_nxt;
    out_status_r <= out_status_nxt;
    out_prime_r  <= out_prime_nxt;
    out_pair_r   <= out_pair_nxt;
  end

  // prime map: one write, two registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem_r[mem_waddr] <= mem_wdata;
    end
    rd_a_r <= map_mem_r[raddr_a];
    rd_b_r <= map_mem_r[raddr_b];
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.primes_found = out_prime_r;
  assign out_ch.pair_count   = out_pair_r;

`ifndef ASSERT_OFF
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_r)
    else $error("read pending while idle");

  a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("accepted word did not start work");

  a_cross_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CROSS) |-> (k_r <= lim_ext))
    else $error("crossing write beyond built limit");

  a_query_needs_map: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QUERY) |-> (built_r && n_r <= built_lim_r))
    else $error("pair walk without a valid map");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_goldbach_pair_counter_unit.sv -----
// testbench for the goldbach pair counter: sieve builds and pair queries checked word by word
`timescale 1ns / 100ps

module tb_goldbach_pair_counter_unit;

  localparam int unsigned NUM_W    = gpc_pkg::NUM_W;
  localparam int unsigned STATUS_W = gpc_pkg::STATUS_W;
  localparam int unsigned PRIME_W  = gpc_pkg::PRIME_W;
  localparam int unsigned PAIR_W   = gpc_pkg::PAIR_W;
  localparam int unsigned PADDR_W  = gpc_pkg::PADDR_W;
  localparam int unsigned PDATA_W  = gpc_pkg::PDATA_W;

  localparam int unsigned MAP_SIZE    = gpc_pkg::SIEVE_SIZE_DEF;
  localparam int unsigned IDLE_PCT    = 19;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_WORDS = 10;
  localparam logic [PADDR_W-1:0] LIMIT_ADDR = {gpc_pkg::REG_SIEVE_LIMIT, 2'b00};
  // first register index past the list
  localparam logic [PADDR_W-1:0] SPARE_ADDR = LIMIT_ADDR + PADDR_W'(4);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PRIME_W-1:0]  primes_found;
    logic [PAIR_W-1:0]   pair_count;
  } gpc_word_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  gpc_in_if  in_ch ();
  gpc_out_if out_ch ();

  goldbach_pair_counter_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // local copy of the block's state
  bit               prime_bits [MAP_SIZE];
  bit               map_done;
  logic [NUM_W-1:0] done_limit;
  logic [NUM_W-1:0] limit_shadow;

  gpc_word_t   expected_words [$];
  int unsigned mismatches    = 0;
  int unsigned words_checked = 0;
  int unsigned builds_sent   = 0;
  int unsigned queries_sent  = 0;
  bit          no_idle       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("run timed out with %0d words outstanding", expected_words.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned sieve_primes(int unsigned lim);
    int unsigned found;
    found = 0;
    foreach (prime_bits[k]) prime_bits[k] = (k >= 2 && k <= lim);
    for (int unsigned p = 2; p * p <= lim; p++) begin
      if (prime_bits[p]) begin
        for (int unsigned k = p * p; k <= lim; k += p) prime_bits[k] = 1'b0;
      end
    end
    for (int unsigned k = 2; k <= lim; k++) found += prime_bits[k];
    return found;
  endfunction

  function automatic gpc_word_t goldbach_result(logic op, logic [NUM_W-1:0] num);
    gpc_word_t   w;
    int unsigned lim;
    int unsigned hits;
    w = '0;
    w.status = gpc_pkg::ST_OK;
    hits = 0;
    if (op == gpc_pkg::OP_BUILD) begin
      lim = limit_shadow;
      if (lim > MAP_SIZE - 1) lim = MAP_SIZE - 1;
      w.primes_found = PRIME_W'(sieve_primes(lim));
      done_limit = NUM_W'(lim);
      map_done = 1'b1;
    end else if (!map_done) begin
      w.status = gpc_pkg::ST_NOT_BUILT;
    end else if (num > done_limit) begin
      w.status = gpc_pkg::ST_RANGE;
    end else begin
      for (int unsigned p1 = 2; p1 <= num / 2; p1++) begin
        if (prime_bits[p1] && prime_bits[num - p1]) hits++;
      end
      w.pair_count = PAIR_W'(hits);
    end
    return w;
  endfunction

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // result side: random back-pressure, none while no_idle is set
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_words
    gpc_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        flag_mismatch("word with nothing expected, status", 0, out_ch.status);
      end else begin
        want = expected_words.pop_front();
        if (out_ch.status !== want.status)
          flag_mismatch("status", want.status, out_ch.status);
        if (out_ch.primes_found !== want.primes_found)
          flag_mismatch("primes_found", want.primes_found, out_ch.primes_found);
        if (out_ch.pair_count !== want.pair_count)
          flag_mismatch("pair_count", want.pair_count, out_ch.pair_count);
      end
    end
  end

  // valid stays high between back-to-back words; it only drops for a gap or in settle
  task automatic send_word(input logic op, input logic [NUM_W-1:0] num);
    if (!no_idle && $urandom_range(99, 0) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    expected_words.push_back(goldbach_result(op, num));
    if (op == gpc_pkg::OP_BUILD) builds_sent++;
    else queries_sent++;
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.number    <= num;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] unused;
    apb_access(1'b1, addr, data, unused);
    if (addr == LIMIT_ADDR) limit_shadow = data[NUM_W-1:0];
  endtask

  task automatic check_limit_readback();
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, LIMIT_ADDR, '0, rd);
    if (rd[NUM_W-1:0] !== limit_shadow)
      flag_mismatch("sieve_limit read back", limit_shadow, rd[NUM_W-1:0]);
  endtask

  task automatic test_query_before_build();
    send_word(gpc_pkg::OP_QUERY, '0);
    send_word(gpc_pkg::OP_QUERY, '1);
    send_word(gpc_pkg::OP_QUERY, NUM_W'(4));
    settle();
  endtask

  // widest sieve; upper data bits of the register write are dropped
  task automatic test_full_map();
    check_limit_readback();
    write_reg(LIMIT_ADDR, '1);
    send_word(gpc_pkg::OP_BUILD, '1);
    send_word(gpc_pkg::OP_QUERY, '1);
    send_word(gpc_pkg::OP_QUERY, NUM_W'(65534));
    for (int n = 0; n <= 5; n++) send_word(gpc_pkg::OP_QUERY, NUM_W'(n));
    settle();
    check_limit_readback();
  endtask

  // limits below the nominal range, then a write to an unmapped register
  task automatic test_tiny_limits();
    logic [NUM_W-1:0] tiny [3] = '{16'd0, 16'd1, 16'd3};
    foreach (tiny[i]) begin
      write_reg(LIMIT_ADDR, PDATA_W'(tiny[i]));
      send_word(gpc_pkg::OP_BUILD, NUM_W'($urandom));
      send_word(gpc_pkg::OP_QUERY, tiny[i]);
      send_word(gpc_pkg::OP_QUERY, tiny[i] + 1'b1);
      settle();
    end
    write_reg(LIMIT_ADDR, PDATA_W'(4));
    send_word(gpc_pkg::OP_BUILD, '0);
    send_word(gpc_pkg::OP_QUERY, NUM_W'(4));
    settle();
    write_reg(SPARE_ADDR, PDATA_W'(16'h0400));
    send_word(gpc_pkg::OP_BUILD, NUM_W'($urandom));
    send_word(gpc_pkg::OP_QUERY, NUM_W'(5));
    settle();
    check_limit_readback();
  endtask

  // each phase: fresh limit, a build, then mostly in-range queries with some noise
  task automatic test_random_phases();
    logic [PDATA_W-1:0] data;
    int unsigned        lim;
    int unsigned        pick;
    for (int ph = 0; ph < PHASES; ph++) begin
      no_idle = (ph == 3);
      lim = ($urandom_range(99, 0) < 80) ? $urandom_range(1500, 4) : $urandom_range(4000, 1500);
      data = $urandom;
      data[NUM_W-1:0] = NUM_W'(lim);
      write_reg(LIMIT_ADDR, data);
      send_word(gpc_pkg::OP_BUILD, NUM_W'($urandom));
      repeat (PHASE_WORDS) begin
        pick = $urandom_range(99, 0);
        if (pick < 72) send_word(gpc_pkg::OP_QUERY, NUM_W'($urandom_range(lim, 0)));
        else if (pick < 88) send_word(gpc_pkg::OP_QUERY, NUM_W'($urandom));
        else if (pick < 95) send_word(gpc_pkg::OP_BUILD, NUM_W'($urandom));
        else send_word(gpc_pkg::OP_QUERY, NUM_W'(lim));
      end
      settle();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = gpc_pkg::OP_BUILD;
    in_ch.number    = '0;
    map_done        = 1'b0;
    done_limit      = '0;
    limit_shadow    = gpc_pkg::SIEVE_LIMIT_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_query_before_build();
    test_full_map();
    test_tiny_limits();
    test_random_phases();

    // catch any stray word after the last expected one
    repeat (20) @(posedge clk);
    $display("checked %0d result words from %0d builds and %0d queries",
             words_checked, builds_sent, queries_sent);
    $display("sieve limits from 0 to 65535, early, in-range and out-of-range queries, stalls");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
